FILE: rtl/wra_pkg.sv
// Shared types and constants of the weighted running average core.
package wra_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int COEF_BITS    = 16;
  localparam int PROD_BITS    = SAMPLE_BITS + COEF_BITS + 1;
  localparam int IDX_BITS     = 4;
  localparam int CFG_BITS     = 5;
  localparam int CNT_BITS     = 4;
  localparam int MAX_TAPS_DEF = 16;

  localparam logic [CNT_BITS-1:0] COUNT_MAX     = 4'd15;
  localparam logic [CFG_BITS-1:0] TAP_COUNT_RST = 5'd1;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                          command;
    logic [IDX_BITS-1:0]           coef_index;
    logic [COEF_BITS-1:0]          coef_value;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          last_out;
  } out_word_t;

  // Per-cycle control broadcast to every cell of the history chain.
  typedef struct packed {
    logic step;
    logic fill;
  } cell_ctrl_t;

  // Valid and end-of-block mark that travel beside the data of a stage.
  typedef struct packed {
    logic valid;
    logic last;
  } stage_tag_t;

endpackage

FILE: rtl/weighted_running_average_core.sv
// Top level of the weighted running average core: control, weights and the cell chain.
//
//   channel   direction  handshake                    word
//   in        input      in_valid_i / in_ready_o      in_word_t (weight load or sample)
//   out       output     out_valid_o / out_ready_i    out_word_t (average, last mark)
//   cfg       input      cfg_we_i, no wait            cfg_data_i (tap count)
//
// One word is taken per cycle while in_ready_o is high. A sample that ends a block also
// issues the rest of the block's outputs, one per cycle unless the output stalls, and the
// input holds off while the chain replays the last sample for the look-ahead, which is
// tap_count - 1 - tap_count / 2. An average passes the cell product registers, the LEVELS
// levels of the four-input adder tree (two for sixteen taps) and the output register.
// Reset clears the control state and the tap count (to one); no clearing pass is run.
// A stalled output fills the tree stages first and then holds off the input.
module weighted_running_average_core
  import wra_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_word_o,
  input  logic                cfg_we_i,
  input  logic [CFG_BITS-1:0] cfg_data_i
);

  localparam int TAP_W = $clog2(MAX_TAPS + 1);
  localparam int CMP_W = ((TAP_W > CNT_BITS) ? TAP_W : CNT_BITS) + 1;

  // Configuration register and the window shape it implies.
  logic [CFG_BITS-1:0] tc_q;
  logic [TAP_W-1:0]    taps, ahead, shamt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= TAP_COUNT_RST;
    end else if (cfg_we_i) begin
      tc_q <= cfg_data_i;
    end
  end

  // A count of zero acts as one and a count above the chain length as the full chain.
  always_comb begin
    if (tc_q == '0) begin
      taps = TAP_W'(1);
    end else if (int'(tc_q) > MAX_TAPS) begin
      taps = TAP_W'(MAX_TAPS);
    end else begin
      taps = TAP_W'(tc_q);
    end
    ahead = taps - TAP_W'(1) - (taps >> 1);
    shamt = TAP_W'(MAX_TAPS) - taps;
  end

  // Input decode and the handshake with the product stage.
  logic       p1_ready, sum_ready;
  logic       flush_q, open_q;
  logic [TAP_W-1:0]    t_q;
  logic [CNT_BITS-1:0] seen_q, seen_new;
  stage_tag_t p1_q;
  logic       accept, is_sample, is_load, flush_step, step, compute, mark;

  assign p1_ready   = !p1_q.valid || sum_ready;
  assign in_ready_o = !flush_q && p1_ready;
  assign accept     = in_valid_i && in_ready_o;
  assign is_sample  = accept && (in_word_i.command == CMD_SAMPLE);
  assign is_load    = accept && (in_word_i.command == CMD_LOAD);
  assign flush_step = flush_q && p1_ready;
  assign step       = is_sample || flush_step;

  always_comb begin
    if (!open_q) begin
      seen_new = CNT_BITS'(1);
    end else if (seen_q == COUNT_MAX) begin
      seen_new = seen_q;
    end else begin
      seen_new = seen_q + CNT_BITS'(1);
    end
  end

  // A sample yields an average once its look-ahead is covered. During a flush, step t
  // stands for the output t places after the newest sample.
  always_comb begin
    if (is_sample) begin
      compute = CMP_W'(seen_new) > CMP_W'(ahead);
      mark    = in_word_i.last_sample && (ahead == '0);
    end else begin
      compute = (CMP_W'(seen_q) + CMP_W'(t_q)) > CMP_W'(ahead);
      mark    = (t_q == ahead);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      flush_q <= 1'b0;
      t_q     <= '0;
      seen_q  <= '0;
    end else if (is_sample) begin
      seen_q <= seen_new;
      if (in_word_i.last_sample) begin
        open_q <= 1'b0;
        if (ahead != '0) begin
          flush_q <= 1'b1;
          t_q     <= TAP_W'(1);
        end
      end else begin
        open_q <= 1'b1;
      end
    end else if (flush_step) begin
      if (t_q == ahead) begin
        flush_q <= 1'b0;
      end else begin
        t_q <= t_q + TAP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= '0;
    end else if (p1_ready) begin
      p1_q.valid <= step && compute;
      p1_q.last  <= mark;
    end
  end

  // Weight registers. An index past the chain is dropped.
  logic [COEF_BITS-1:0]          w_q [MAX_TAPS];
  logic [MAX_TAPS*COEF_BITS-1:0] wvec, wshift;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_TAPS; i++) begin
      if (is_load && (int'(in_word_i.coef_index) == i)) begin
        w_q[i] <= in_word_i.coef_value;
      end
    end
  end

  // Cell j meets weight taps-1-j: reverse the weights, then shift the window into place.
  // Cells at or past the window end read zero from the vacated positions.
  always_comb begin
    for (int j = 0; j < MAX_TAPS; j++) begin
      wvec[j*COEF_BITS +: COEF_BITS] = w_q[MAX_TAPS-1-j];
    end
    wshift = wvec >> (int'(shamt) * COEF_BITS);
  end

  // The cell chain. Cell zero takes the new sample, or its own value again while
  // a flush replays the right edge of the block.
  cell_ctrl_t                    ctrl;
  logic signed [SAMPLE_BITS-1:0] hist [MAX_TAPS];
  logic signed [PROD_BITS-1:0]   prod [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] head_in;

  assign ctrl.step = step;
  assign ctrl.fill = is_sample && !open_q;
  assign head_in   = is_sample ? in_word_i.sample : hist[0];

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] nbr;
    if (j == 0) begin : g_head
      assign nbr = head_in;
    end else begin : g_body
      assign nbr = hist[j-1];
    end
    wra_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .fill_val_i (in_word_i.sample),
      .nbr_i      (nbr),
      .weight_i   (wshift[j*COEF_BITS +: COEF_BITS]),
      .hist_o     (hist[j]),
      .prod_o     (prod[j])
    );
  end

  wra_sum #(
    .MAX_TAPS (MAX_TAPS)
  ) u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .prod_i      (prod),
    .tag_i       (p1_q),
    .ready_o     (sum_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  // A block's last sample with look-ahead starts a flush, beginning at step one.
  a_flush_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_sample && in_word_i.last_sample && (ahead != '0) |=> flush_q && (t_q == TAP_W'(1)))
    else $error("flush did not start after the last sample");

  // The final flush step ends the flush.
  a_flush_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_step && (t_q == ahead) |=> !flush_q)
    else $error("flush ran past its final step");

  // The block is closed for the whole flush.
  a_flush_closed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> !open_q)
    else $error("block open during flush");

  // The last step of a flush always issues the marked final average.
  a_flush_mark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_step && (t_q == ahead) |=> p1_q.valid && p1_q.last)
    else $error("final flush step lost its average");

endmodule

FILE: rtl/wra_cell.sv
// One history cell: holds a sample, passes it on and forms its weighted product.
module wra_cell
  import wra_pkg::*;
(
  input  logic                          clk_i,
  input  cell_ctrl_t                    ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] fill_val_i,
  input  logic signed [SAMPLE_BITS-1:0] nbr_i,
  input  logic [COEF_BITS-1:0]          weight_i,
  output logic signed [SAMPLE_BITS-1:0] hist_o,
  output logic signed [PROD_BITS-1:0]   prod_o
);

  logic signed [SAMPLE_BITS-1:0] hist_q, hist_d;
  logic signed [PROD_BITS-1:0]   prod_q;

  // A block start loads every cell with the same sample.
  assign hist_d = ctrl_i.fill ? fill_val_i : nbr_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      hist_q <= hist_d;
      prod_q <= PROD_BITS'(hist_d) * PROD_BITS'($signed({1'b0, weight_i}));
    end
  end

  assign hist_o = hist_q;
  assign prod_o = prod_q;

endmodule

FILE: rtl/wra_sum.sv
// Registered adder tree over the cell products, rounding, saturation and output register.
module wra_sum
  import wra_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic signed [PROD_BITS-1:0] prod_i [MAX_TAPS],
  input  stage_tag_t                  tag_i,
  output logic                        ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output out_word_t                   out_word_o
);

  localparam int ACC_BITS = PROD_BITS + $clog2(MAX_TAPS);
  // Four inputs per node; three levels reach at most 64 taps.
  localparam int LEVELS   = (MAX_TAPS <= 4) ? 1 : ((MAX_TAPS <= 16) ? 2 : 3);

  localparam logic signed [ACC_BITS-1:0] SAT_HI =
    {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] SAT_LO = ~SAT_HI;

  logic signed [ACC_BITS-1:0] tree_in [LEVELS][MAX_TAPS];
  logic signed [ACC_BITS-1:0] node_q  [LEVELS][MAX_TAPS];
  logic [LEVELS-1:0]          vld_q, lst_q;
  logic [LEVELS:0]            rdy;
  logic                       out_valid_q;
  out_word_t                  out_word_q;

  assign rdy[LEVELS] = !out_valid_q || out_ready_i;

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    logic vld_in, lst_in;

    assign rdy[l] = !vld_q[l] || rdy[l+1];

    if (l == 0) begin : g_tag_in
      assign vld_in = tag_i.valid;
      assign lst_in = tag_i.last;
    end else begin : g_tag_fwd
      assign vld_in = vld_q[l-1];
      assign lst_in = lst_q[l-1];
    end

    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_in
      if (l == 0) begin : g_first
        assign tree_in[l][k] = ACC_BITS'(prod_i[k]);
      end else begin : g_next
        assign tree_in[l][k] = node_q[l-1][k];
      end
    end

    for (genvar i = 0; i < MAX_TAPS; i++) begin : g_node
      logic signed [ACC_BITS-1:0] term [4];
      for (genvar j = 0; j < 4; j++) begin : g_term
        if (4 * i + j < MAX_TAPS) begin : g_used
          assign term[j] = tree_in[l][4*i+j];
        end else begin : g_pad
          assign term[j] = '0;
        end
      end
      always_ff @(posedge clk_i) begin
        if (rdy[l]) begin
          node_q[l][i] <= (term[0] + term[1]) + (term[2] + term[3]);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[l] <= 1'b0;
        lst_q[l] <= 1'b0;
      end else if (rdy[l]) begin
        vld_q[l] <= vld_in;
        lst_q[l] <= lst_in;
      end
    end
  end

  // Shift right with truncation toward zero, then clamp to the sample range.
  logic signed [ACC_BITS-1:0] acc, bias, quot;
  logic signed [SAMPLE_BITS-1:0] avg;

  always_comb begin
    acc  = node_q[LEVELS-1][0];
    bias = '0;
    if (acc[ACC_BITS-1]) begin
      bias[COEF_BITS-1:0] = '1;
    end
    quot = (acc + bias) >>> COEF_BITS;
    if (quot > SAT_HI) begin
      avg = SAT_HI[SAMPLE_BITS-1:0];
    end else if (quot < SAT_LO) begin
      avg = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      avg = quot[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy[LEVELS]) begin
      out_valid_q <= vld_q[LEVELS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[LEVELS]) begin
      out_word_q.average  <= avg;
      out_word_q.last_out <= lst_q[LEVELS-1];
    end
  end

  assign ready_o     = rdy[0];
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: verif/weighted_running_average_core_tb.sv
// Self-checking testbench for the weighted running average core.
`timescale 1ns / 1ps

module weighted_running_average_core_tb
  import wra_pkg::*;
();

  // Directed stimulus row: an optional tap count write ahead of the word, and for
  // rows whose result is obvious, the average typed in by hand.
  typedef struct packed {
    logic                 set_taps;
    logic [CFG_BITS-1:0]  taps;
    in_word_t             word;
    logic                 known;
    out_word_t            result;
  } dir_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_word_t            in_word_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_word_t           out_word_o;
  logic                cfg_we_i    = 1'b0;
  logic [CFG_BITS-1:0] cfg_data_i  = '0;

  // Shadow of the datapath: sample history (newest first), weights, block tracking
  // and the tap count register as last written.
  logic signed [SAMPLE_BITS-1:0] hist_q [MAX_TAPS_DEF];
  logic [COEF_BITS-1:0]          wt_q   [MAX_TAPS_DEF];
  int                            seen_cnt  = 0;
  bit                            blk_open  = 1'b0;
  logic [CFG_BITS-1:0]           taps_reg  = TAP_COUNT_RST;

  // Averages that the core owes us, oldest first.
  out_word_t avg_due_q [$];

  dir_row_t dir_tab [$];

  // Tap counts visited by the random phases; both ends and the out-of-range codes.
  logic [CFG_BITS-1:0] tap_plan [12] = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd17, 5'd8,
                                         5'd5, 5'd2, 5'd24, 5'd3, 5'd12, 5'd7};

  int mismatch_cnt = 0;
  int words_sent   = 0;
  int samples_sent = 0;
  int loads_sent   = 0;
  int blocks_done  = 0;
  int avgs_seen    = 0;
  int tap_settings = 0;
  int burst_left   = 0;
  int wt_shift     = 0;
  bit drained_once = 1'b0;

  weighted_running_average_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The generous limit covers the real work many times over.
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic flag_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A tap count of zero behaves as one, anything past the array size as the full array.
  function automatic int taps_in_effect();
    if (taps_reg == 0) return 1;
    if (taps_reg > MAX_TAPS_DEF) return MAX_TAPS_DEF;
    return int'(taps_reg);
  endfunction

  function automatic void shift_sample(logic signed [SAMPLE_BITS-1:0] s);
    int i;
    for (i = MAX_TAPS_DEF - 1; i > 0; i--) hist_q[i] = hist_q[i-1];
    hist_q[0] = s;
  endfunction

  // Weight k meets the sample that is taps-1-k places behind the newest one. The sum
  // is divided by 2^COEF_BITS rounding toward zero, then clipped to the sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] window_average(int taps);
    longint acc;
    longint q;
    int     k;
    acc = 0;
    for (k = 0; k < taps; k++)
      acc += longint'(hist_q[taps-1-k]) * longint'(wt_q[k]);
    if (acc < 0) q = -((-acc) >>> COEF_BITS);
    else q = acc >>> COEF_BITS;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[SAMPLE_BITS-1:0];
  endfunction

  // Applies one accepted word to the shadow state. With keep set, the averages it
  // releases are queued for checking; otherwise the caller queues a typed-in one.
  function automatic void advance_average(in_word_t w, bit keep);
    int        taps;
    int        ahead;
    int        t;
    int        i;
    out_word_t r;
    out_word_t flush_q [$];
    taps  = taps_in_effect();
    ahead = taps - 1 - taps / 2;
    if (w.command == CMD_LOAD) begin
      wt_q[w.coef_index] = w.coef_value;
      return;
    end
    // The first sample of a block fills the whole history, replicating the left edge.
    if (!blk_open) begin
      for (i = 0; i < MAX_TAPS_DEF; i++) hist_q[i] = w.sample;
      seen_cnt = 0;
      blk_open = 1'b1;
    end else begin
      shift_sample(w.sample);
    end
    if (seen_cnt < COUNT_MAX) seen_cnt++;
    if (!w.last_sample) begin
      if (seen_cnt > ahead && keep) begin
        r.average  = window_average(taps);
        r.last_out = 1'b0;
        avg_due_q.push_back(r);
      end
      return;
    end
    // Flush: every pending average goes out, the last sample being shifted in again
    // between them to replicate the right edge. Short blocks give fewer averages.
    for (t = 0; t <= ahead; t++) begin
      if (seen_cnt + t > ahead) begin
        r.average  = window_average(taps);
        r.last_out = 1'b0;
        flush_q.push_back(r);
      end
      shift_sample(w.sample);
    end
    if (flush_q.size() > 0) flush_q[flush_q.size()-1].last_out = 1'b1;
    if (keep) foreach (flush_q[i]) avg_due_q.push_back(flush_q[i]);
    blk_open = 1'b0;
    seen_cnt = 0;
    blocks_done++;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: stall pattern and checking
  // ---------------------------------------------------------------------------

  // The receiver cycles through modes: always ready, random, a fixed one-in-five
  // stall, and mostly stalled. Each mode lasts a random stretch of cycles.
  int rdy_mode  = 0;
  int rdy_left  = 0;
  int rdy_phase = 0;

  always @(posedge clk_i) begin
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_left = $urandom_range(20, 120);
    end else begin
      rdy_left--;
    end
    rdy_phase++;
    case (rdy_mode)
      0: begin
        out_ready_i <= 1'b1;
      end
      1: begin
        out_ready_i <= ($urandom_range(0, 9) < 7);
      end
      2: begin
        out_ready_i <= (rdy_phase % 5 != 0);
      end
      default: begin
        out_ready_i <= (rdy_phase % 4 == 0);
      end
    endcase
  end

  // Signals read right after the edge still hold their values from before it.
  always @(posedge clk_i) begin : avg_check
    out_word_t due;
    if (rst_ni && out_valid_o && out_ready_i) begin
      avgs_seen++;
      if (avg_due_q.size() == 0) begin
        flag_mismatch($sformatf("average %0d (last %0b) with none expected",
                                out_word_o.average, out_word_o.last_out));
      end else begin
        due = avg_due_q.pop_front();
        if (out_word_o.average !== due.average)
          flag_mismatch($sformatf("average %0d, expected %0d",
                                  out_word_o.average, due.average));
        if (out_word_o.last_out !== due.last_out)
          flag_mismatch($sformatf("last mark %0b, expected %0b (average %0d)",
                                  out_word_o.last_out, due.last_out, due.average));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  function automatic in_word_t load_word(int idx, logic [COEF_BITS-1:0] val);
    in_word_t w;
    w.command     = CMD_LOAD;
    w.coef_index  = idx[IDX_BITS-1:0];
    w.coef_value  = val;
    // Sample fields are don't-care on a load, so fill them with noise.
    w.sample      = SAMPLE_BITS'($urandom);
    w.last_sample = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic in_word_t sample_word(int s, int last);
    in_word_t w;
    w.command     = CMD_SAMPLE;
    w.coef_index  = IDX_BITS'($urandom);
    w.coef_value  = COEF_BITS'($urandom);
    w.sample      = SAMPLE_BITS'(s);
    w.last_sample = last[0];
    return w;
  endfunction

  function automatic dir_row_t mk_row(int set_taps, int taps, in_word_t w, int known,
                                      int avg, int last);
    dir_row_t r;
    r.set_taps        = set_taps[0];
    r.taps            = CFG_BITS'(taps);
    r.word            = w;
    r.known           = known[0];
    r.result.average  = SAMPLE_BITS'(avg);
    r.result.last_out = last[0];
    return r;
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(0, 7))
      0: return 32767;
      1: return -32768;
      2: return int'($urandom_range(0, 15)) - 8;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_BITS-1:0] pick_weight();
    logic [COEF_BITS-1:0] v;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: begin
        v = COEF_BITS'($urandom);
        return v >> wt_shift;
      end
    endcase
  endfunction

  // Sender: bursts of random length, separated by random gaps (sometimes none).
  // Called right after a rising edge; returns right after the accepting edge.
  task automatic send_word(in_word_t w, bit keep);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    words_sent++;
    if (w.command == CMD_LOAD) loads_sent++;
    else samples_sent++;
    advance_average(w, keep);
  endtask

  // Holds the input off until every owed average has come out.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (avg_due_q.size() != 0) @(posedge clk_i);
  endtask

  // Drains the core and then waits out the flush replay and the adder tree, so
  // that nothing is in flight when the tap count changes.
  task automatic quiesce();
    hold_until_drained();
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_taps(logic [CFG_BITS-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    taps_reg   = v;
    tap_settings++;
  endtask

  task automatic reload_weights();
    int idx;
    wt_shift = $urandom_range(0, 4);
    for (idx = 0; idx < MAX_TAPS_DEF; idx++) send_word(load_word(idx, pick_weight()), 1'b1);
  endtask

  // One block of samples with occasional weight loads mixed in. Most blocks are
  // short so that the flush paths get exercised often; a few run past the point
  // where the sample count saturates.
  task automatic send_block();
    int len;
    int i;
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) len = $urandom_range(1, 5);
    else if (r < 9) len = $urandom_range(6, 12);
    else len = $urandom_range(13, 20);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_word(load_word($urandom_range(0, MAX_TAPS_DEF - 1), pick_weight()), 1'b1);
      // Pause mid-block at least once until the core has caught up completely.
      if (i > 0 && (!drained_once || $urandom_range(0, 40) == 0)) begin
        hold_until_drained();
        drained_once = 1'b1;
      end
      send_word(sample_word(pick_sample(), int'(i == len - 1)), 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int phase;
    int dir_words;
    int phase_start;

    // Directed part. One tap: half weight shows truncation toward zero on both
    // signs, zero weight gives zero, full-scale weight just under unity. Two taps
    // of full weight saturate at both ends. Tap count zero acts as one. Five taps
    // give a look-ahead of two: a one-sample and a two-sample short block, the
    // latter with a weight change in the middle of the block.
    dir_tab.push_back(mk_row(1, 5'd1, load_word(0, 16'h8000), 0, 0, 0));
    dir_tab.push_back(mk_row(0, 0, sample_word(16'sh7FFF, 1), 1, 16383, 1));
    dir_tab.push_back(mk_row(0, 0, sample_word(16'sh8000, 1), 1, -16384, 1));
    dir_tab.push_back(mk_row(0, 0, sample_word(-1, 1), 1, 0, 1));
    dir_tab.push_back(mk_row(0, 0, load_word(0, 16'h0000), 0, 0, 0));
    dir_tab.push_back(mk_row(0, 0, sample_word(16'sh1234, 1), 1, 0, 1));
    dir_tab.push_back(mk_row(0, 0, load_word(0, 16'hFFFF), 0, 0, 0));
    dir_tab.push_back(mk_row(0, 0, sample_word(16'sh7FFF, 1), 1, 32766, 1));
    dir_tab.push_back(mk_row(1, 5'd2, load_word(1, 16'hFFFF), 0, 0, 0));
    dir_tab.push_back(mk_row(0, 0, sample_word(16'sh7FFF, 1), 1, 32767, 1));
    dir_tab.push_back(mk_row(0, 0, sample_word(16'sh8000, 1), 1, -32768, 1));
    dir_tab.push_back(mk_row(1, 5'd0, sample_word(100, 0), 0, 0, 0));
    dir_tab.push_back(mk_row(0, 0, sample_word(-100, 1), 0, 0, 0));
    dir_tab.push_back(mk_row(1, 5'd5, load_word(2, 16'h4000), 0, 0, 0));
    dir_tab.push_back(mk_row(0, 0, load_word(3, 16'h2000), 0, 0, 0));
    dir_tab.push_back(mk_row(0, 0, load_word(4, 16'h1000), 0, 0, 0));
    dir_tab.push_back(mk_row(0, 0, sample_word(1000, 1), 0, 0, 0));
    dir_tab.push_back(mk_row(0, 0, sample_word(-2000, 0), 0, 0, 0));
    dir_tab.push_back(mk_row(0, 0, load_word(0, 16'h1111), 0, 0, 0));
    dir_tab.push_back(mk_row(0, 0, sample_word(3000, 1), 0, 0, 0));

    foreach (hist_q[i]) hist_q[i] = '0;
    foreach (wt_q[i]) wt_q[i] = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Rows with a typed-in average queue that value and let the predictor only
    // track state; all other rows are checked against the predictor.
    foreach (dir_tab[i]) begin
      if (dir_tab[i].set_taps) begin
        quiesce();
        write_taps(dir_tab[i].taps);
      end
      if (dir_tab[i].known) avg_due_q.push_back(dir_tab[i].result);
      send_word(dir_tab[i].word, !dir_tab[i].known);
    end
    dir_words = words_sent;

    // Random part: one tap count per phase, written while the core is idle. The
    // first phase loads every weight so that no unwritten weight is ever read.
    phase = 0;
    while (words_sent < dir_words + 240) begin
      quiesce();
      write_taps((phase < 12) ? tap_plan[phase] : 5'($urandom_range(0, 31)));
      if (phase == 0 || $urandom_range(0, 1) == 1) reload_weights();
      phase_start = words_sent;
      while (words_sent < phase_start + 25) send_block();
      phase++;
    end

    quiesce();
    $display("Sent %0d words (%0d samples, %0d weight loads) in %0d blocks over %0d tap settings.",
             words_sent, samples_sent, loads_sent, blocks_done, tap_settings);
    $display("Checked %0d averages against the predictor; %0d mismatches.",
             avgs_seen, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/wra_pkg.sv
rtl/wra_cell.sv
rtl/wra_sum.sv
rtl/weighted_running_average_core.sv
verif/weighted_running_average_core_tb.sv
